FILE: rtl/core/depth_minmax_jet_colorizer_unit_defines.svh
// Assertion macros used by the top RTL file of the depth colorizer.
`ifndef DEPTH_MINMAX_JET_COLORIZER_UNIT_DEFINES_SVH
`define DEPTH_MINMAX_JET_COLORIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DMJC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dmjc check failed");

// Next-cycle implication, checked outside reset.
`define DMJC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmjc check failed");

`endif

FILE: rtl/core/dmjc_pkg.sv
// ----------------------------------------------------------------------------
// dmjc_pkg
// Shared constants of the depth min/max jet colorizer.
// ----------------------------------------------------------------------------
`default_nettype none
package dmjc_pkg;
    localparam int unsigned MAX_PIXELS = 524288;
    localparam int unsigned ADDR_W     = $clog2(MAX_PIXELS);
    localparam int unsigned CNT_W      = ADDR_W + 1;
    localparam int unsigned DEPTH_W    = 16;
    localparam int unsigned WIDTH_W    = 11;
    localparam int unsigned HEIGHT_W   = 10;
    localparam int unsigned INDEX_W    = 19;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FRAME = 2'd1;
    localparam logic [1:0] ST_NO_VALID = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [1:0] SEG_RISE_G = 2'd0;
    localparam logic [1:0] SEG_FALL_B = 2'd1;
    localparam logic [1:0] SEG_RISE_R = 2'd2;
    localparam logic [1:0] SEG_FALL_G = 2'd3;

    typedef logic [DEPTH_W-1:0] t_depth;
endpackage
`default_nettype wire

FILE: rtl/core/dmjc_frame_store.sv
// ----------------------------------------------------------------------------
// dmjc_frame_store
// Frame memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module dmjc_frame_store (
    input  wire                         i_clk,
    input  wire                         i_we,
    input  wire [dmjc_pkg::ADDR_W-1:0]  i_waddr,
    input  wire dmjc_pkg::t_depth       i_wdata,
    input  wire                         i_re,
    input  wire [dmjc_pkg::ADDR_W-1:0]  i_raddr,
    output dmjc_pkg::t_depth            o_rdata
);
    import dmjc_pkg::*;

    t_depth r_mem [MAX_PIXELS];
    t_depth r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: rtl/core/dmjc_divider.sv
// ----------------------------------------------------------------------------
// dmjc_divider
// Restoring divider, one quotient bit per cycle, for quotients below 2^16.
// ----------------------------------------------------------------------------
`default_nettype none
module dmjc_divider (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire [31:0]            i_num,
    input  wire dmjc_pkg::t_depth i_den,
    output logic                  o_done,
    output dmjc_pkg::t_depth      o_quo
);
    import dmjc_pkg::*;

    t_depth      r_rem;
    t_depth      r_low;
    t_depth      r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] shifted;
    logic        ge;
    t_depth      n_rem;

    always_comb begin
        shifted = {r_rem, r_low[15]};
        ge      = shifted >= {1'b0, r_den};
        n_rem   = ge ? 16'(shifted - {1'b0, r_den}) : shifted[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[31:16];
            r_low <= i_num[15:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[14:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_low;
endmodule
`default_nettype wire

FILE: rtl/core/depth_minmax_jet_colorizer_unit.sv
// ----------------------------------------------------------------------------
// depth_minmax_jet_colorizer_unit
// Loads a depth frame, tracks min/max of valid samples, reads normalized
// level and jet colour per pixel.
// ----------------------------------------------------------------------------
// Channel | Ports                                          | Handshake
// cmd     | i_mode i_depth_sample i_pixel_index            | i_start, o_busy
// result  | o_red o_green o_blue o_normalized_level        | o_valid strobe
//         | o_pixel_valid o_frame_done o_status            |
// config  | i_cfg_index i_cfg_wdata                        | i_cfg_we
//
// A load beat or a read beat that fails a check answers in the next cycle.
// A read of a zero sample or of a flat frame answers from the memory read
// state, with no divider pass. Any other read holds busy for the memory
// read state and two shared divider passes (level, then colour channel).
// Reset is synchronous; no memory clearing pass is needed.
// Results cannot be stalled; each is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "depth_minmax_jet_colorizer_unit_defines.svh"
module depth_minmax_jet_colorizer_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    output logic                         o_busy,
    input  wire                          i_mode,
    input  wire dmjc_pkg::t_depth        i_depth_sample,
    input  wire [dmjc_pkg::INDEX_W-1:0]  i_pixel_index,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire [dmjc_pkg::WIDTH_W-1:0]  i_cfg_wdata,
    output logic                         o_valid,
    output logic [7:0]                   o_red,
    output logic [7:0]                   o_green,
    output logic [7:0]                   o_blue,
    output dmjc_pkg::t_depth             o_normalized_level,
    output logic                         o_pixel_valid,
    output logic                         o_frame_done,
    output logic [1:0]                   o_status
);
    import dmjc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_DIVL = 2'd2;
    localparam logic [1:0] S_DIVC = 2'd3;

    logic [1:0]          r_state;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [CNT_W-1:0]    r_size;
    logic [CNT_W-1:0]    r_cnt;
    t_depth              r_min;
    t_depth              r_max;
    logic                r_any;
    logic                r_ready;

    t_depth              r_x;
    t_depth              r_rng;
    t_depth              r_level;
    logic [1:0]          r_seg;

    logic                r_valid;
    logic [7:0]          r_red;
    logic [7:0]          r_green;
    logic [7:0]          r_blue;
    t_depth              r_lvl_out;
    logic                r_pvalid;
    logic                r_fdone;
    logic [1:0]          r_status;

    logic                accept;
    logic                do_load;
    logic                do_read;
    logic [CNT_W-1:0]    eff_cnt;
    t_depth              eff_min;
    t_depth              eff_max;
    logic                eff_any;
    logic                wr_en;
    logic [CNT_W-1:0]    n_cnt;
    logic [WIDTH_W-1:0]  n_width;
    logic [HEIGHT_W-1:0] n_height;
    logic [20:0]         prod;
    logic [CNT_W-1:0]    n_size;
    t_depth              rdata;
    logic                div_start;
    logic [31:0]         div_num;
    t_depth              div_den;
    logic                div_done;
    t_depth              div_quo;
    logic [17:0]         x4;
    logic [17:0]         r2;
    logic [17:0]         r3;
    logic [17:0]         r4;
    logic [1:0]          n_seg;
    t_depth              seg_num;
    logic [23:0]         col_num;

    assign accept  = i_start && (r_state == S_IDLE);
    assign do_load = accept && !i_mode;
    assign do_read = accept && i_mode;

    always_comb begin
        eff_cnt = r_ready ? '0 : r_cnt;
        eff_min = r_ready ? '1 : r_min;
        eff_max = r_ready ? '0 : r_max;
        eff_any = r_ready ? 1'b0 : r_any;
        wr_en   = do_load && (eff_cnt < r_size);
        n_cnt   = wr_en ? eff_cnt + 1'b1 : eff_cnt;
    end

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        case (i_cfg_index)
            REG_WIDTH:  n_width  = i_cfg_wdata;
            REG_HEIGHT: n_height = i_cfg_wdata[HEIGHT_W-1:0];
            default:    n_width  = r_width;
        endcase
        prod = n_width * n_height;
        if (prod > 21'(MAX_PIXELS)) begin
            n_size = CNT_W'(MAX_PIXELS);
        end else if (prod == '0) begin
            n_size = CNT_W'(1);
        end else begin
            n_size = prod[CNT_W-1:0];
        end
    end

    always_comb begin
        x4  = {r_x, 2'b00};
        r2  = {1'b0, r_rng, 1'b0};
        r3  = r2 + {2'b00, r_rng};
        r4  = {r_rng, 2'b00};
        if (x4 < {2'b00, r_rng}) begin
            n_seg   = SEG_RISE_G;
            seg_num = x4[15:0];
        end else if (x4 < r2) begin
            n_seg   = SEG_FALL_B;
            seg_num = 16'(r2 - x4);
        end else if (x4 < r3) begin
            n_seg   = SEG_RISE_R;
            seg_num = 16'(x4 - r2);
        end else begin
            n_seg   = SEG_FALL_G;
            seg_num = 16'(r4 - x4);
        end
        col_num = {seg_num, 8'd0} - {8'd0, seg_num};
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = {r_x, 16'd0} - {16'd0, r_x};
        div_den   = r_rng;
        if (r_state == S_RD) begin
            div_start = (rdata != '0) && (r_max != r_min);
            div_num   = {rdata - r_min, 16'd0} - {16'd0, rdata - r_min};
            div_den   = r_max - r_min;
        end else if (r_state == S_DIVL && div_done) begin
            div_start = 1'b1;
            div_num   = {8'd0, col_num};
        end
    end

    dmjc_frame_store u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (eff_cnt[ADDR_W-1:0]),
        .i_wdata (i_depth_sample),
        .i_re    (do_read),
        .i_raddr (i_pixel_index[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    dmjc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= WIDTH_W'(640);
            r_height <= HEIGHT_W'(480);
            r_size   <= CNT_W'(307200);
            r_cnt    <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_any    <= 1'b0;
            r_ready  <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_width  <= n_width;
                r_height <= n_height;
                r_size   <= n_size;
                r_cnt    <= '0;
                r_min    <= '1;
                r_max    <= '0;
                r_any    <= 1'b0;
                r_ready  <= 1'b0;
            end else if (do_load) begin
                r_cnt   <= n_cnt;
                r_min   <= eff_min;
                r_max   <= eff_max;
                r_any   <= eff_any;
                r_ready <= n_cnt >= r_size;
                if (wr_en && i_depth_sample != '0) begin
                    r_any <= 1'b1;
                    if (i_depth_sample < eff_min) begin
                        r_min <= i_depth_sample;
                    end
                    if (i_depth_sample > eff_max) begin
                        r_max <= i_depth_sample;
                    end
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (do_load) begin
                        r_valid <= 1'b1;
                    end else if (do_read) begin
                        if (!r_ready || !r_any ||
                            {1'b0, i_pixel_index} >= r_size) begin
                            r_valid <= 1'b1;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (!div_start) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_DIVL;
                    end
                end
                S_DIVL: begin
                    if (div_done) begin
                        r_state <= S_DIVC;
                    end
                end
                S_DIVC: begin
                    if (div_done) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_red     <= 8'd0;
                r_green   <= 8'd0;
                r_blue    <= 8'd0;
                r_lvl_out <= '0;
                r_pvalid  <= 1'b0;
                r_fdone   <= do_load && (n_cnt >= r_size);
                r_status  <= ST_OK;
                if (do_read) begin
                    if (!r_ready) begin
                        r_status <= ST_NO_FRAME;
                    end else if (!r_any) begin
                        r_status <= ST_NO_VALID;
                    end else if ({1'b0, i_pixel_index} >= r_size) begin
                        r_status <= ST_RANGE;
                    end
                end
            end
            S_RD: begin
                r_x   <= rdata - r_min;
                r_rng <= r_max - r_min;
                if (rdata != '0 && r_max == r_min) begin
                    r_red     <= 8'd255;
                    r_lvl_out <= '1;
                    r_pvalid  <= 1'b1;
                end
            end
            S_DIVL: begin
                if (div_done) begin
                    r_level <= div_quo;
                    r_seg   <= n_seg;
                end
            end
            S_DIVC: begin
                if (div_done) begin
                    r_lvl_out <= r_level;
                    r_pvalid  <= 1'b1;
                    case (r_seg)
                        SEG_RISE_G: begin
                            r_red <= 8'd0;   r_green <= div_quo[7:0]; r_blue <= 8'd255;
                        end
                        SEG_FALL_B: begin
                            r_red <= 8'd0;   r_green <= 8'd255; r_blue <= div_quo[7:0];
                        end
                        SEG_RISE_R: begin
                            r_red <= div_quo[7:0]; r_green <= 8'd255; r_blue <= 8'd0;
                        end
                        default: begin
                            r_red <= 8'd255; r_green <= div_quo[7:0]; r_blue <= 8'd0;
                        end
                    endcase
                end
            end
            default: r_status <= ST_OK;
        endcase
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_valid            = r_valid;
    assign o_red              = r_red;
    assign o_green            = r_green;
    assign o_blue             = r_blue;
    assign o_normalized_level = r_lvl_out;
    assign o_pixel_valid      = r_pvalid;
    assign o_frame_done       = r_fdone;
    assign o_status           = r_status;

    `DMJC_ASSERT_NOW(a_valid_idle, r_valid, r_state == S_IDLE)
    `DMJC_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= r_size)
    `DMJC_ASSERT_NOW(a_pix_ok, r_valid && r_pvalid, r_status == ST_OK && !r_fdone)
    `DMJC_ASSERT_NEXT(a_load_answers, do_load && !i_cfg_we, r_valid)
endmodule
`default_nettype wire

FILE: tb/sv/depth_minmax_jet_colorizer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_minmax_jet_colorizer_unit_test
// Self-checking bench for the depth colorizer. It loads small frames, reads
// pixels back and compares every result beat against an in-bench model of the
// min/max normalizer and jet colormap. It covers directed corner cases, frame
// size extremes and random frames with random gaps on the command side.
// ----------------------------------------------------------------------------
module depth_minmax_jet_colorizer_unit_test;
    import dmjc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        t_depth      level;
        logic        pix_valid;
        logic        frame_done;
        logic [1:0]  status;
    } t_pixel_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic                 i_mode;
    t_depth               i_depth_sample;
    logic [INDEX_W-1:0]   i_pixel_index;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [WIDTH_W-1:0]   i_cfg_wdata;
    logic                 o_valid;
    logic [7:0]           o_red;
    logic [7:0]           o_green;
    logic [7:0]           o_blue;
    t_depth               o_normalized_level;
    logic                 o_pixel_valid;
    logic                 o_frame_done;
    logic [1:0]           o_status;

    depth_minmax_jet_colorizer_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_mode(i_mode), .i_depth_sample(i_depth_sample),
        .i_pixel_index(i_pixel_index), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_red(o_red), .o_green(o_green), .o_blue(o_blue),
        .o_normalized_level(o_normalized_level), .o_pixel_valid(o_pixel_valid),
        .o_frame_done(o_frame_done), .o_status(o_status)
    );

    // Model state.
    logic [15:0]          frame_mem [int];
    int unsigned          cur_width;
    int unsigned          cur_height;
    int unsigned          cur_min;
    int unsigned          cur_max;
    bit                   seen_valid;
    int unsigned          loaded;
    bit                   frame_ok;

    t_pixel_result        pending_pixels[$];
    int                   error_count;
    int                   beat_count;
    int                   idle_cycles;
    bit                   quiet_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned frame_pixels();
        longint unsigned n;
        n = longint'(cur_width) * longint'(cur_height);
        if (n > MAX_PIXELS) n = MAX_PIXELS;
        if (n == 0) n = 1;
        return int'(n);
    endfunction

    function automatic void restart_model();
        cur_min = 16'hFFFF;
        cur_max = 0;
        seen_valid = 1'b0;
        loaded = 0;
        frame_ok = 1'b0;
    endfunction

    function automatic longint unsigned scale8(longint unsigned num, longint unsigned den);
        return (255 * num) / den;
    endfunction

    function automatic t_pixel_result colorize(bit mode, t_depth sample, int unsigned idx);
        t_pixel_result   res;
        int unsigned     size;
        longint unsigned d, rng, x, x4;
        res = '0;
        size = frame_pixels();
        if (!mode) begin
            if (frame_ok) restart_model();
            if (loaded < size) begin
                frame_mem[loaded] = sample;
                if (sample != 0) begin
                    if (sample < cur_min) cur_min = sample;
                    if (sample > cur_max) cur_max = sample;
                    seen_valid = 1'b1;
                end
                loaded++;
            end
            if (loaded >= size) begin
                frame_ok = 1'b1;
                res.frame_done = 1'b1;
            end
            return res;
        end
        if (!frame_ok) begin
            res.status = ST_NO_FRAME;
        end else if (!seen_valid) begin
            res.status = ST_NO_VALID;
        end else if (idx >= size) begin
            res.status = ST_RANGE;
        end else begin
            d = frame_mem[idx];
            if (d != 0) begin
                res.pix_valid = 1'b1;
                if (cur_max == cur_min) begin
                    res.level = 16'hFFFF;
                    res.red = 8'd255;
                end else begin
                    rng = cur_max - cur_min;
                    x = d - cur_min;
                    x4 = 4 * x;
                    res.level = t_depth'((65535 * x) / rng);
                    if (x4 < rng) begin
                        res.green = 8'(scale8(x4, rng));
                        res.blue = 8'd255;
                    end else if (x4 < 2 * rng) begin
                        res.green = 8'd255;
                        res.blue = 8'(scale8(2 * rng - x4, rng));
                    end else if (x4 < 3 * rng) begin
                        res.red = 8'(scale8(x4 - 2 * rng, rng));
                        res.green = 8'd255;
                    end else begin
                        res.red = 8'd255;
                        res.green = 8'(scale8(4 * rng - x4, rng));
                    end
                end
            end
        end
        return res;
    endfunction

    // Sends one command beat; start stays high afterwards unless a random gap drops it.
    task automatic send_beat(bit mode, t_depth sample, int unsigned idx);
        t_pixel_result exp_res;
        i_start <= 1'b1;
        i_mode <= mode;
        i_depth_sample <= sample;
        i_pixel_index <= idx[INDEX_W-1:0];
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        exp_res = colorize(mode, sample, 32'(idx[INDEX_W-1:0]));
        pending_pixels = {pending_pixels, exp_res};
        beat_count++;
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic reg_idx, int unsigned value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_index <= reg_idx;
        i_cfg_wdata <= value[WIDTH_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (reg_idx == REG_WIDTH) cur_width = value & 32'h7FF;
        else cur_height = value & 32'h3FF;
        restart_model();
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic test_reset_state();
        send_beat(1'b1, 16'h0000, 0);
        send_beat(1'b1, 16'hFFFF, 32'h7FFFF);
    endtask

    task automatic test_small_frame();
        set_frame(2, 2);
        send_beat(1'b0, 16'd0, 0);
        send_beat(1'b0, 16'd100, 0);
        send_beat(1'b1, 16'd0, 1);
        send_beat(1'b0, 16'd100, 0);
        send_beat(1'b0, 16'hFFFF, 0);
        for (int i = 0; i < 4; i++) send_beat(1'b1, 16'h0000, i);
        send_beat(1'b1, 16'h0000, 4);
        send_beat(1'b1, 16'h0000, 32'h7FFFF);
        send_beat(1'b0, 16'd1, 0);
        send_beat(1'b1, 16'h0000, 0);
    endtask

    task automatic test_flat_and_empty();
        set_frame(1, 1);
        send_beat(1'b0, 16'd7, 0);
        send_beat(1'b1, 16'h0000, 0);
        send_beat(1'b1, 16'h0000, 1);
        set_frame(2, 1);
        send_beat(1'b0, 16'd0, 0);
        send_beat(1'b0, 16'd0, 0);
        send_beat(1'b1, 16'h0000, 0);
    endtask

    task automatic test_size_extremes();
        set_frame(1024, 512);
        send_beat(1'b0, 16'd5, 0);
        send_beat(1'b1, 16'd0, 0);
        set_frame(0, 3);
        for (int i = 0; i < 2; i++) send_beat(1'b0, t_depth'(9 + i), 0);
        send_beat(1'b1, 16'd0, 0);
        write_reg(REG_WIDTH, 32'h7FF);
        write_reg(REG_HEIGHT, 32'h3FF);
        send_beat(1'b1, 16'd0, 0);
        set_frame(1, 1023);
        send_beat(1'b0, 16'd3, 0);
        send_beat(1'b1, 16'd0, 0);
    endtask

    task automatic test_random_frames();
        int unsigned w, h, size, base, span, samp, nreads, idx;
        while (beat_count < 530) begin
            if (beat_count > 450) quiet_mode = 1'b1;
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_frame(w, h);
            size = w * h;
            base = $urandom_range(1, 65535);
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) :
                                                  $urandom_range(0, 65535);
            if ($urandom_range(0, 7) == 0) send_beat(1'b1, t_depth'($urandom), $urandom);
            for (int i = 0; i < size; i++) begin
                samp = base + ($urandom % (span + 1));
                if (samp > 65535) samp = 65535 - ($urandom % 64);
                if ($urandom_range(0, 6) == 0) samp = 0;
                if ($urandom_range(0, 15) == 0) samp = $urandom_range(0, 65535);
                send_beat(1'b0, t_depth'(samp), $urandom);
            end
            nreads = $urandom_range(1, size + 2);
            for (int i = 0; i < nreads; i++) begin
                idx = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, size);
                send_beat(1'b1, t_depth'($urandom), idx);
            end
            if ($urandom_range(0, 5) == 0) begin
                send_beat(1'b0, t_depth'($urandom), $urandom);
                send_beat(1'b1, t_depth'($urandom), 0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_result e;
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid || i_cfg_we) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
            if (o_valid) begin
                if (pending_pixels.size() == 0) begin
                    $error("unexpected result beat");
                    error_count++;
                end else begin
                    e = pending_pixels.pop_front();
                    if (o_red !== e.red) begin
                        $error("red exp %0d got %0d", e.red, o_red); error_count++;
                    end
                    if (o_green !== e.green) begin
                        $error("green exp %0d got %0d", e.green, o_green); error_count++;
                    end
                    if (o_blue !== e.blue) begin
                        $error("blue exp %0d got %0d", e.blue, o_blue); error_count++;
                    end
                    if (o_normalized_level !== e.level) begin
                        $error("normalized_level exp %0d got %0d", e.level,
                               o_normalized_level);
                        error_count++;
                    end
                    if (o_pixel_valid !== e.pix_valid) begin
                        $error("pixel_valid exp %0d got %0d", e.pix_valid, o_pixel_valid);
                        error_count++;
                    end
                    if (o_frame_done !== e.frame_done) begin
                        $error("frame_done exp %0d got %0d", e.frame_done, o_frame_done);
                        error_count++;
                    end
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_mode = 1'b0;
        i_depth_sample = '0;
        i_pixel_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_wdata = '0;
        error_count = 0;
        beat_count = 0;
        idle_cycles = 0;
        quiet_mode = 1'b0;
        cur_width = 640;
        cur_height = 480;
        restart_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_small_frame();
        test_flat_and_empty();
        test_size_extremes();
        test_random_frames();
        drain_results();
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/dmjc_pkg.sv
rtl/core/dmjc_frame_store.sv
rtl/core/dmjc_divider.sv
rtl/core/depth_minmax_jet_colorizer_unit.sv
tb/sv/depth_minmax_jet_colorizer_unit_test.sv
